/* design/attention_kv_cache_engine_top_assert.svh */
// ----------------------------------------------------------------------------
// Attention KV cache engine assertion macros
// Shared property forms for the top level checks.
// ----------------------------------------------------------------------------
`ifndef ATTENTION_KV_CACHE_ENGINE_TOP_ASSERT_SVH
`define ATTENTION_KV_CACHE_ENGINE_TOP_ASSERT_SVH

// same-cycle implication
`define AKV_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define AKV_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* design/akv_pkg.sv */
// ----------------------------------------------------------------------------
// Attention KV cache engine package
// Shared codes, command type and arithmetic helpers.
// ----------------------------------------------------------------------------
package akv_pkg;

	localparam int HEAD_DIM_DEF = 16;
	localparam int HEADS_DEF    = 4;
	localparam int MAX_POS_DEF  = 256;

	localparam logic [1:0] OP_LOAD  = 2'd0;
	localparam logic [1:0] OP_QUERY = 2'd1;
	localparam logic [1:0] OP_END   = 2'd2;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	typedef struct packed {
		logic [1:0]         kind;
		logic signed [15:0] key;
		logic signed [15:0] value;
		logic signed [15:0] query;
	} cmd_t;

	function automatic logic [17:0] isqrt_floor(input logic [63:0] q);
		logic [63:0] s;
		logic [63:0] t;
		s = '0;
		for (int b = 17; b >= 0; b--) begin
			t = s | (64'd1 << b);
			if (t * t <= q) begin
				s = t;
			end
		end
		return s[17:0];
	endfunction

	// 2^(-k/16) in Q1.16
	function automatic logic [16:0] pow2_tab(input logic [4:0] idx);
		logic [16:0] v;
		unique case (idx)
			5'd0:  v = 17'd65536;
			5'd1:  v = 17'd62757;
			5'd2:  v = 17'd60097;
			5'd3:  v = 17'd57549;
			5'd4:  v = 17'd55109;
			5'd5:  v = 17'd52773;
			5'd6:  v = 17'd50535;
			5'd7:  v = 17'd48393;
			5'd8:  v = 17'd46341;
			5'd9:  v = 17'd44376;
			5'd10: v = 17'd42495;
			5'd11: v = 17'd40693;
			5'd12: v = 17'd38968;
			5'd13: v = 17'd37316;
			5'd14: v = 17'd35734;
			5'd15: v = 17'd34219;
			5'd16: v = 17'd32768;
			default: v = 17'd0;
		endcase
		return v;
	endfunction

	// y: exponent in Q.11 (log2 domain); returns 2^-y in Q1.16
	function automatic logic [16:0] exp_neg(input logic [34:0] y);
		logic [23:0] n;
		logic [3:0]  k;
		logic [6:0]  r;
		logic [16:0] tk;
		logic [16:0] tk1;
		logic [23:0] dp;
		logic [16:0] t;
		n   = y[34:11];
		k   = y[10:7];
		r   = y[6:0];
		tk  = pow2_tab({1'b0, k});
		tk1 = pow2_tab({1'b0, k} + 5'd1);
		dp  = 24'(tk - tk1) * 24'(r);
		t   = tk - 17'(dp >> 7);
		if (n >= 24'd17) begin
			return '0;
		end
		return t >> n[4:0];
	endfunction

endpackage

/* design/akv_front.sv */
// ----------------------------------------------------------------------------
// Attention KV cache engine front end
// Takes command beats, drops unused opcodes, queues the rest for the back end.
// ----------------------------------------------------------------------------
module akv_front import akv_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [1:0]        opcode,
	input  logic signed [15:0] key_elem,
	input  logic signed [15:0] value_elem,
	input  logic signed [15:0] query_elem,
	output logic              cmd_valid,
	output cmd_t              cmd,
	input  logic              cmd_pop
);

	cmd_t       fifo_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       push;
	logic       useful;

	assign busy      = (cnt_q == 2'd2);
	assign useful    = (opcode == OP_LOAD) || (opcode == OP_QUERY) || (opcode == OP_END);
	assign push      = start && !busy && useful;
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd       = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= '{kind: opcode, key: key_elem, value: value_elem,
				query: query_elem};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (cmd_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(cmd_pop);
		end
	end

endmodule

/* design/akv_div.sv */
// ----------------------------------------------------------------------------
// Attention KV cache engine weight divider
// Restoring divider, one quotient bit per cycle: (num << 16) / den, num <= den.
// ----------------------------------------------------------------------------
module akv_div import akv_pkg::*; #(
	parameter int DEN_W = 26
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             go,
	input  logic [16:0]      num,
	input  logic [DEN_W-1:0] den,
	output logic             done,
	output logic [16:0]      quot
);

	logic [DEN_W:0]   rem_q;
	logic [DEN_W-1:0] den_q;
	logic [16:0]      quot_q;
	logic [4:0]       cnt_q;
	logic             run_q;
	logic             done_q;
	logic             ge;
	logic [DEN_W:0]   diff;

	assign ge   = (rem_q >= {1'b0, den_q});
	assign diff = ge ? (rem_q - {1'b0, den_q}) : rem_q;
	assign done = done_q;
	assign quot = quot_q;

	always_ff @(posedge clk) begin
		if (go) begin
			rem_q  <= (DEN_W + 1)'(num);
			den_q  <= den;
			quot_q <= '0;
		end else if (run_q) begin
			rem_q  <= {diff[DEN_W-1:0], 1'b0};
			quot_q <= {quot_q[15:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= 5'd16;
			end else if (run_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd0) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

/* design/akv_back.sv */
// ----------------------------------------------------------------------------
// Attention KV cache engine back end
// Position store, query buffer and the attention sequencer.
// ----------------------------------------------------------------------------
module akv_back import akv_pkg::*; #(
	parameter int HEAD_DIM = HEAD_DIM_DEF,
	parameter int HEADS    = HEADS_DEF,
	parameter int MAX_POS  = MAX_POS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	input  cmd_t               cmd,
	output logic               cmd_pop,
	input  logic               use_cache,
	output logic               result_valid,
	output logic signed [15:0] context_elem,
	output logic               last,
	output logic [1:0]         status
);

	localparam int HidN  = HEADS * HEAD_DIM;
	localparam int Depth = MAX_POS * HidN;
	localparam int AW    = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int DW    = (HEAD_DIM > 1) ? $clog2(HEAD_DIM) : 1;
	localparam int HW    = (HEADS > 1) ? $clog2(HEADS) : 1;
	localparam int PW    = (MAX_POS > 1) ? $clog2(MAX_POS) : 1;
	localparam int CW    = $clog2(MAX_POS + 1);
	localparam int LW    = (HidN > 1) ? $clog2(HidN) : 1;
	localparam int SumW  = 17 + CW;
	localparam int DotW  = 33 + DW;
	localparam int AccW  = 34 + PW + DW;
	localparam int SpW   = DotW + 19;
	localparam logic [63:0] ScaleNum = (64'd1 << 32) / HEAD_DIM;
	localparam logic [17:0] Scale    = isqrt_floor(ScaleNum);
	localparam logic signed [SpW-1:0]  RndSc = SpW'(64'd1 << 26);
	localparam logic signed [AccW-1:0] RndCx = AccW'(64'd1 << 15);

	localparam logic [2:0] S_IDLE    = 3'd0;
	localparam logic [2:0] S_EMPTY   = 3'd1;
	localparam logic [2:0] S_SC      = 3'd2;
	localparam logic [2:0] S_EX      = 3'd3;
	localparam logic [2:0] S_DV_RD   = 3'd4;
	localparam logic [2:0] S_DV_GO   = 3'd5;
	localparam logic [2:0] S_DV_WAIT = 3'd6;
	localparam logic [2:0] S_VS      = 3'd7;

	logic [2:0]      state_q;
	logic [CW-1:0]   pos_cnt_q;
	logic [AW-1:0]   load_addr_q;
	logic [LW-1:0]   load_idx_q;
	logic [DW-1:0]   q_elem_q;
	logic [HW-1:0]   q_head_q;
	logic [AW-1:0]   head_off_q;
	logic [PW-1:0]   j_q;
	logic [DW-1:0]   d_q;
	logic [AW-1:0]   jbase_q;
	logic            iss_q;
	logic [PW-1:0]   wr_j_q;
	logic signed [31:0] mx_q;
	logic [SumW-1:0] sum_q;
	logic            res_v_q;
	logic signed [15:0] ctx_q;
	logic            last_q;
	logic [1:0]      status_q;

	logic signed [15:0] qbuf_q [HEAD_DIM];
	logic [15:0]     key_mem [Depth];
	logic [15:0]     val_mem [Depth];
	logic [31:0]     sc_mem  [MAX_POS];

	logic               pv_s1, gf_s1, gl_s1, al_s1;
	logic signed [15:0] q_s1;
	logic [15:0]        key_rd_s1;
	logic [15:0]        val_rd_s1;
	logic [31:0]        sc_rd_s1;
	logic               pv_s2, gf_s2, gl_s2, al_s2;
	logic signed [32:0] prod_s2;
	logic               ey_v_s2, ey_l_s2;
	logic [34:0]        y_s2;
	logic signed [AccW-1:0] acc_q;
	logic               rv_s3, al_s3;
	logic signed [AccW-1:0] res_s3;
	logic               sv_s4, al_s4;
	logic signed [SpW-1:0] sp_s4;

	logic [CW-1:0]   pos_last;
	logic            jlast, dlast;
	logic [AW-1:0]   rd_addr;
	logic            is_full;
	logic            mem_we;
	logic            sc_we;
	logic [PW-1:0]   sc_wa;
	logic [31:0]     sc_wd;
	logic signed [16:0] a_s1;
	logic signed [15:0] b_s1;
	logic signed [AccW-1:0] sum_now;
	logic signed [SpW-1:0]  sc_sum;
	logic signed [SpW-1:0]  sc_sh;
	logic signed [31:0]     sc32;
	logic signed [32:0]     ex_diff;
	logic signed [45:0]     ex_prod;
	logic [16:0]     e_val;
	logic signed [AccW-1:0] cx_sum;
	logic signed [AccW-1:0] cx_sh;
	logic signed [15:0] cx_sat;
	logic            div_go;
	logic            div_done;
	logic [16:0]     div_quot;
	logic [15:0]     w_sat;

	assign pos_last = pos_cnt_q - CW'(1);
	assign jlast    = (CW'(j_q) == pos_last);
	assign dlast    = (d_q == DW'(HEAD_DIM - 1));
	assign rd_addr  = jbase_q + head_off_q + AW'(d_q);
	assign is_full  = (pos_cnt_q == CW'(MAX_POS));
	assign cmd_pop  = (state_q == S_IDLE) && cmd_valid;
	assign mem_we   = cmd_pop && (cmd.kind == OP_LOAD) && !is_full;

	assign result_valid = res_v_q;
	assign context_elem = ctx_q;
	assign last         = last_q;
	assign status       = status_q;

	// multiplier operands: query x key for scores, weight x value for context
	assign a_s1 = (state_q == S_SC) ? 17'(q_s1) : $signed({1'b0, sc_rd_s1[15:0]});
	assign b_s1 = (state_q == S_SC) ? $signed(key_rd_s1) : $signed(val_rd_s1);
	assign sum_now = gf_s2 ? AccW'(prod_s2) : acc_q + AccW'(prod_s2);

	assign sc_sum = sp_s4 + RndSc;
	assign sc_sh  = sc_sum >>> 27;
	assign sc32   = sc_sh[31:0];

	assign ex_diff = $signed({mx_q[31], mx_q}) - $signed({sc_rd_s1[31], sc_rd_s1});
	assign ex_prod = ex_diff * 46'sd2955;
	assign e_val   = exp_neg(y_s2);

	assign cx_sum = res_s3 + RndCx;
	assign cx_sh  = cx_sum >>> 16;
	always_comb begin
		if (cx_sh > AccW'(32767)) begin
			cx_sat = 16'sd32767;
		end else if (cx_sh < -AccW'(32768)) begin
			cx_sat = -16'sd32768;
		end else begin
			cx_sat = cx_sh[15:0];
		end
	end

	assign w_sat  = div_quot[16] ? 16'hFFFF : div_quot[15:0];
	assign div_go = (state_q == S_DV_GO);

	always_comb begin
		sc_we = 1'b0;
		sc_wa = wr_j_q;
		sc_wd = 32'(sc32);
		unique case (state_q)
			S_SC: begin
				sc_we = sv_s4;
			end
			S_EX: begin
				sc_we = ey_v_s2;
				sc_wd = 32'(e_val);
			end
			S_DV_WAIT: begin
				sc_we = div_done;
				sc_wa = j_q;
				sc_wd = 32'(w_sat);
			end
			default: begin
				sc_we = 1'b0;
			end
		endcase
	end

	akv_div #(.DEN_W(SumW)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (div_go),
		.num    (sc_rd_s1[16:0]),
		.den    (sum_q),
		.done   (div_done),
		.quot   (div_quot)
	);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			key_mem[load_addr_q] <= cmd.key;
			val_mem[load_addr_q] <= cmd.value;
		end
		key_rd_s1 <= key_mem[rd_addr];
		val_rd_s1 <= val_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (sc_we) begin
			sc_mem[sc_wa] <= sc_wd;
		end
		sc_rd_s1 <= sc_mem[j_q];
	end

	always_ff @(posedge clk) begin
		if (cmd_pop && (cmd.kind == OP_QUERY)) begin
			qbuf_q[q_elem_q] <= cmd.query;
		end
		q_s1    <= qbuf_q[d_q];
		prod_s2 <= a_s1 * b_s1;
		y_s2    <= ex_prod[45:11];
		if (pv_s2) begin
			acc_q <= sum_now;
		end
		if (pv_s2 && gl_s2) begin
			res_s3 <= sum_now;
		end
		sp_s4 <= $signed(res_s3[DotW-1:0]) * $signed({1'b0, Scale});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pv_s1   <= 1'b0;
			gf_s1   <= 1'b0;
			gl_s1   <= 1'b0;
			al_s1   <= 1'b0;
			pv_s2   <= 1'b0;
			gf_s2   <= 1'b0;
			gl_s2   <= 1'b0;
			al_s2   <= 1'b0;
			ey_v_s2 <= 1'b0;
			ey_l_s2 <= 1'b0;
			rv_s3   <= 1'b0;
			al_s3   <= 1'b0;
			sv_s4   <= 1'b0;
			al_s4   <= 1'b0;
		end else begin
			pv_s1 <= iss_q;
			gf_s1 <= (state_q == S_SC) ? (d_q == '0) : (j_q == '0);
			gl_s1 <= (state_q == S_SC) ? dlast : jlast;
			al_s1 <= (state_q == S_EX) ? jlast : (dlast && jlast);
			pv_s2   <= pv_s1 && (state_q != S_EX);
			gf_s2   <= gf_s1;
			gl_s2   <= gl_s1;
			al_s2   <= al_s1;
			ey_v_s2 <= pv_s1 && (state_q == S_EX);
			ey_l_s2 <= al_s1;
			rv_s3   <= pv_s2 && gl_s2;
			al_s3   <= al_s2;
			sv_s4   <= rv_s3 && (state_q == S_SC);
			al_s4   <= al_s3;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			pos_cnt_q   <= '0;
			load_addr_q <= '0;
			load_idx_q  <= '0;
			q_elem_q    <= '0;
			q_head_q    <= '0;
			head_off_q  <= '0;
			j_q         <= '0;
			d_q         <= '0;
			jbase_q     <= '0;
			iss_q       <= 1'b0;
			wr_j_q      <= '0;
			mx_q        <= '0;
			sum_q       <= '0;
			res_v_q     <= 1'b0;
			ctx_q       <= '0;
			last_q      <= 1'b0;
			status_q    <= ST_OK;
		end else begin
			res_v_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						priority case (cmd.kind)
							OP_LOAD: begin
								if (is_full) begin
									res_v_q  <= 1'b1;
									ctx_q    <= '0;
									last_q   <= 1'b1;
									status_q <= ST_FULL;
								end else begin
									load_addr_q <= load_addr_q + AW'(1);
									if (load_idx_q == LW'(HidN - 1)) begin
										load_idx_q <= '0;
										pos_cnt_q  <= pos_cnt_q + CW'(1);
									end else begin
										load_idx_q <= load_idx_q + LW'(1);
									end
								end
							end
							OP_QUERY: begin
								if (q_elem_q == DW'(HEAD_DIM - 1)) begin
									q_elem_q   <= '0;
									head_off_q <= AW'(q_head_q * HEAD_DIM);
									q_head_q   <= (q_head_q == HW'(HEADS - 1)) ? '0 :
										q_head_q + HW'(1);
									d_q        <= '0;
									j_q        <= '0;
									jbase_q    <= '0;
									wr_j_q     <= '0;
									if (pos_cnt_q == '0) begin
										state_q <= S_EMPTY;
									end else begin
										state_q <= S_SC;
										iss_q   <= 1'b1;
									end
								end else begin
									q_elem_q <= q_elem_q + DW'(1);
								end
							end
							default: begin
								if (!use_cache) begin
									pos_cnt_q   <= '0;
									load_addr_q <= '0;
								end else begin
									load_addr_q <= AW'(pos_cnt_q * HidN);
								end
								load_idx_q <= '0;
								q_elem_q   <= '0;
								q_head_q   <= '0;
							end
						endcase
					end
				end
				S_EMPTY: begin
					res_v_q  <= 1'b1;
					ctx_q    <= '0;
					last_q   <= dlast;
					status_q <= ST_EMPTY;
					d_q      <= d_q + DW'(1);
					if (dlast) begin
						d_q     <= '0;
						state_q <= S_IDLE;
					end
				end
				S_SC: begin
					if (iss_q) begin
						if (dlast) begin
							d_q <= '0;
							if (jlast) begin
								iss_q <= 1'b0;
							end else begin
								j_q     <= j_q + PW'(1);
								jbase_q <= jbase_q + AW'(HidN);
							end
						end else begin
							d_q <= d_q + DW'(1);
						end
					end
					if (sv_s4) begin
						wr_j_q <= wr_j_q + PW'(1);
						if ((wr_j_q == '0) || (sc32 > mx_q)) begin
							mx_q <= sc32;
						end
						if (al_s4) begin
							state_q <= S_EX;
							iss_q   <= 1'b1;
							j_q     <= '0;
							wr_j_q  <= '0;
							sum_q   <= '0;
						end
					end
				end
				S_EX: begin
					if (iss_q) begin
						if (jlast) begin
							iss_q <= 1'b0;
						end else begin
							j_q <= j_q + PW'(1);
						end
					end
					if (ey_v_s2) begin
						sum_q  <= sum_q + SumW'(e_val);
						wr_j_q <= wr_j_q + PW'(1);
						if (ey_l_s2) begin
							state_q <= S_DV_RD;
							j_q     <= '0;
						end
					end
				end
				S_DV_RD: begin
					state_q <= S_DV_GO;
				end
				S_DV_GO: begin
					state_q <= S_DV_WAIT;
				end
				S_DV_WAIT: begin
					if (div_done) begin
						if (jlast) begin
							state_q <= S_VS;
							iss_q   <= 1'b1;
							j_q     <= '0;
							d_q     <= '0;
							jbase_q <= '0;
						end else begin
							j_q     <= j_q + PW'(1);
							state_q <= S_DV_RD;
						end
					end
				end
				S_VS: begin
					if (iss_q) begin
						if (jlast) begin
							j_q     <= '0;
							jbase_q <= '0;
							if (dlast) begin
								iss_q <= 1'b0;
							end else begin
								d_q <= d_q + DW'(1);
							end
						end else begin
							j_q     <= j_q + PW'(1);
							jbase_q <= jbase_q + AW'(HidN);
						end
					end
					if (rv_s3) begin
						res_v_q  <= 1'b1;
						ctx_q    <= cx_sat;
						last_q   <= al_s3;
						status_q <= ST_OK;
						if (al_s3) begin
							state_q <= S_IDLE;
							d_q     <= '0;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

/* design/attention_kv_cache_engine_top.sv */
// ----------------------------------------------------------------------------
// Attention KV cache engine
// Scaled dot-product attention over a key/value position store, fixed point.
// ----------------------------------------------------------------------------
// channel   direction  handshake            payload
// command   in         start & !busy        opcode, key_elem, value_elem, query_elem
// config    in         cfg_valid&cfg_ready  cfg_data (use_cache)
// result    out        result_valid strobe  context_elem, last, status
//
// Load, end-of-call and non-final query beats are popped straight from S_IDLE;
// a two-entry queue lets the front keep taking beats while the back end works.
// A head's final query beat starts the run over its n stored positions: scores,
// then exponents, then weights in the one-bit-per-cycle weight divider, then the
// value sums; scores and value sums share one multiplier. Reset clears all
// counters; the stores need no clearing.
// Results are strobed for one cycle and cannot be stalled.
// ----------------------------------------------------------------------------
`include "attention_kv_cache_engine_top_assert.svh"

module attention_kv_cache_engine_top import akv_pkg::*; #(
	parameter int HEAD_DIM = HEAD_DIM_DEF,
	parameter int HEADS    = HEADS_DEF,
	parameter int MAX_POS  = MAX_POS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         opcode,
	input  logic signed [15:0] key_elem,
	input  logic signed [15:0] value_elem,
	input  logic signed [15:0] query_elem,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic               cfg_data,
	output logic               result_valid,
	output logic signed [15:0] context_elem,
	output logic               last,
	output logic [1:0]         status
);

	logic use_cache_q;
	logic cmd_valid;
	cmd_t cmd;
	logic cmd_pop;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			use_cache_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			use_cache_q <= cfg_data;
		end
	end

	akv_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.opcode     (opcode),
		.key_elem   (key_elem),
		.value_elem (value_elem),
		.query_elem (query_elem),
		.cmd_valid  (cmd_valid),
		.cmd        (cmd),
		.cmd_pop    (cmd_pop)
	);

	akv_back #(
		.HEAD_DIM (HEAD_DIM),
		.HEADS    (HEADS),
		.MAX_POS  (MAX_POS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (cmd_valid),
		.cmd          (cmd),
		.cmd_pop      (cmd_pop),
		.use_cache    (use_cache_q),
		.result_valid (result_valid),
		.context_elem (context_elem),
		.last         (last),
		.status       (status)
	);

	`AKV_ASSERT_IMP(a_full_single, result_valid && (status == ST_FULL), last && (context_elem == 16'sd0), "full beat must be single and zero")
	`AKV_ASSERT_IMP(a_empty_zero, result_valid && (status == ST_EMPTY), context_elem == 16'sd0, "empty-store beat must be zero")
	`AKV_ASSERT_NXT(a_end_queued, start && !busy && (opcode == OP_END), cmd_valid, "accepted command not queued")

endmodule
